// ===== src/iafc_pkg.sv =====
// shared types and codes for the iec 104 apci frame checker
// no dependencies; used by every module of the block
package iafc_pkg;

    localparam int unsigned ByteW      = 8;
    localparam int unsigned CountW     = 9;
    localparam int unsigned CfgW       = 2;
    localparam int unsigned CfgIndexW  = 1;
    localparam int unsigned ResultW    = 98;
    localparam int unsigned OutDataW   = 104;

    localparam logic [CountW-1:0] MaxCount  = 9'd511;
    localparam logic [ByteW-1:0]  StartMark = 8'h68;

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] CFG_CAUSE_BYTES = 1'd0;
    localparam logic [CfgIndexW-1:0] CFG_ADDR_BYTES  = 1'd1;

    // verdict codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT       = 4'd1;
    localparam logic [3:0] ST_BAD_START   = 4'd2;
    localparam logic [3:0] ST_LEN_EXCEEDS = 4'd3;
    localparam logic [3:0] ST_U_NONE      = 4'd4;
    localparam logic [3:0] ST_U_MULTIPLE  = 4'd5;
    localparam logic [3:0] ST_U_LENGTH    = 4'd6;
    localparam logic [3:0] ST_U_NONZERO   = 4'd7;
    localparam logic [3:0] ST_S_CONTROL   = 4'd8;
    localparam logic [3:0] ST_S_NONZERO   = 4'd9;
    localparam logic [3:0] ST_ODD_RECV    = 4'd10;
    localparam logic [3:0] ST_S_LENGTH    = 4'd11;
    localparam logic [3:0] ST_I_SHORT     = 4'd12;

    // frame kinds
    localparam logic [1:0] KIND_I = 2'd0;
    localparam logic [1:0] KIND_S = 2'd1;
    localparam logic [1:0] KIND_U = 2'd2;

    // bytes of a frame seen so far
    typedef struct packed {
        logic [CountW-1:0]      byte_count;
        logic [ByteW-1:0]       start_byte;
        logic [ByteW-1:0]       declared_length;
        logic [3:0][ByteW-1:0]  control_bytes;
        logic [ByteW-1:0]       type_byte;
        logic [ByteW-1:0]       qualifier_byte;
        logic [1:0][ByteW-1:0]  cause_store;
        logic [1:0][ByteW-1:0]  address_store;
    } frame_t;

    // one verdict, first field in the highest bits
    typedef struct packed {
        logic [7:0]  asdu_length;
        logic [15:0] common_address;
        logic [15:0] cause;
        logic [7:0]  asdu_qualifier;
        logic [7:0]  asdu_type;
        logic [5:0]  u_function;
        logic [14:0] recv_seq;
        logic [14:0] send_seq;
        logic [1:0]  frame_kind;
        logic [3:0]  status;
    } result_t;

endpackage

// ===== src/iafc_capture.sv =====
// input register and per-frame byte store of the apci frame checker
// depends on iafc_pkg
module iafc_capture (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte
    input  logic                  s_tlast,   // last_byte
    input  logic                  out_busy,
    output iafc_pkg::frame_t      frame_snap,
    output logic                  frame_done
);
    import iafc_pkg::*;

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_last_reg;
    logic             advance;
    frame_t           frame_reg;
    frame_t           frame_next;
    logic [CountW-1:0] pos;

    // last byte waits only while the result register is held
    assign advance    = in_valid_reg && (!in_last_reg || !out_busy);
    assign s_tready   = !in_valid_reg || advance;
    assign frame_done = advance && in_last_reg;
    assign pos        = frame_reg.byte_count;

    always_comb
    begin
        frame_next = frame_reg;
        if (pos == 9'd0)
        begin
            frame_next.start_byte = in_byte_reg;
        end
        if (pos == 9'd1)
        begin
            frame_next.declared_length = in_byte_reg;
        end
        if (pos >= 9'd2 && pos <= 9'd5)
        begin
            frame_next.control_bytes[pos[1:0] - 2'd2] = in_byte_reg;
        end
        if (pos == 9'd6)
        begin
            frame_next.type_byte = in_byte_reg;
        end
        if (pos == 9'd7)
        begin
            frame_next.qualifier_byte = in_byte_reg;
        end
        if (pos == 9'd8 || pos == 9'd9)
        begin
            frame_next.cause_store[pos[0]] = in_byte_reg;
        end
        if (pos == 9'd10 || pos == 9'd11)
        begin
            frame_next.address_store[pos[0]] = in_byte_reg;
        end
        if (pos != MaxCount)
        begin
            frame_next.byte_count = pos + 9'd1;
        end
    end

    assign frame_snap = frame_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            frame_reg    <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                if (in_last_reg)
                begin
                    frame_reg <= '0;
                end
                else
                begin
                    frame_reg <= frame_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

endmodule

// ===== src/iafc_verdict.sv =====
// combinational frame checks and header field extraction
// depends on iafc_pkg
module iafc_verdict (
    input  iafc_pkg::frame_t       frame_snap,
    input  logic [1:0]             cause_bytes,
    input  logic [1:0]             common_addr_bytes,
    output iafc_pkg::result_t      result
);
    import iafc_pkg::*;

    logic [CountW-1:0] cnt;
    logic [CountW-1:0] frame_len;
    logic [ByteW-1:0]  c0, c1, c2, c3;
    logic [ByteW-1:0]  w8, w9, w10, w11;
    logic              cause_two;
    logic              addr_two;
    logic              len_is_6;
    logic [5:0]        ubits;
    logic              u_none;
    logic              u_multi;

    assign cnt       = frame_snap.byte_count;
    assign frame_len = {1'b0, frame_snap.declared_length} + 9'd2;
    assign c0        = frame_snap.control_bytes[0];
    assign c1        = frame_snap.control_bytes[1];
    assign c2        = frame_snap.control_bytes[2];
    assign c3        = frame_snap.control_bytes[3];
    assign cause_two = (cause_bytes != 2'd1);
    assign addr_two  = (common_addr_bytes != 2'd1);
    assign len_is_6  = (frame_len == 9'd6);
    assign ubits     = c0[7:2];
    assign u_none    = (ubits == 6'd0);
    assign u_multi   = ((ubits & (ubits - 6'd1)) != 6'd0);

    // header bytes beyond the buffer read as zero
    assign w8  = (cnt > 9'd8)  ? frame_snap.cause_store[0]   : 8'd0;
    assign w9  = (cnt > 9'd9)  ? frame_snap.cause_store[1]   : 8'd0;
    assign w10 = (cnt > 9'd10) ? frame_snap.address_store[0] : 8'd0;
    assign w11 = (cnt > 9'd11) ? frame_snap.address_store[1] : 8'd0;

    always_comb
    begin
        result = '0;
        priority if (cnt < 9'd6)
        begin
            result.status = ST_SHORT;
        end
        else if (frame_snap.start_byte != StartMark)
        begin
            result.status = ST_BAD_START;
        end
        else if (frame_len > cnt)
        begin
            result.status = ST_LEN_EXCEEDS;
        end
        else
        begin
            if (!len_is_6)
            begin
                result.asdu_type      = (cnt > 9'd6) ? frame_snap.type_byte : 8'd0;
                result.asdu_qualifier = (cnt > 9'd7) ? frame_snap.qualifier_byte : 8'd0;
                result.cause          = {cause_two ? w9 : 8'd0, w8};
                if (cause_two)
                begin
                    result.common_address = {addr_two ? w11 : 8'd0, w10};
                end
                else
                begin
                    result.common_address = {addr_two ? w10 : 8'd0, w9};
                end
            end
            result.asdu_length = (frame_snap.declared_length > 8'd4)
                               ? frame_snap.declared_length - 8'd4 : 8'd0;

            if (c0[0] && c0[1])
            begin
                result.frame_kind = KIND_U;
                result.u_function = ubits;
                priority if (u_none)
                begin
                    result.status = ST_U_NONE;
                end
                else if (u_multi)
                begin
                    result.status = ST_U_MULTIPLE;
                end
                else if (!len_is_6)
                begin
                    result.status = ST_U_LENGTH;
                end
                else if (c1 != 8'd0 || c2 != 8'd0 || c3 != 8'd0)
                begin
                    result.status = ST_U_NONZERO;
                end
                else
                begin
                    result.status = ST_OK;
                end
            end
            else if (c0[0])
            begin
                result.frame_kind = KIND_S;
                result.recv_seq   = {c3, c2[7:1]};
                priority if (c0 != 8'h01)
                begin
                    result.status = ST_S_CONTROL;
                end
                else if (c1 != 8'd0)
                begin
                    result.status = ST_S_NONZERO;
                end
                else if (c2[0])
                begin
                    result.status = ST_ODD_RECV;
                end
                else if (!len_is_6)
                begin
                    result.status = ST_S_LENGTH;
                end
                else
                begin
                    result.status = ST_OK;
                end
            end
            else
            begin
                result.frame_kind = KIND_I;
                result.send_seq   = {c1, c0[7:1]};
                result.recv_seq   = {c3, c2[7:1]};
                priority if (c2[0])
                begin
                    result.status = ST_ODD_RECV;
                end
                else if (frame_len <= 9'd6)
                begin
                    result.status = ST_I_SHORT;
                end
                else
                begin
                    result.status = ST_OK;
                end
            end
        end
    end

endmodule

// ===== src/iec104_apci_frame_checker_top.sv =====
// top level of the iec 104 apci frame checker: config registers and result register
// depends on iafc_pkg, iafc_capture and iafc_verdict
//
// The checker takes one received buffer as a byte stream, one byte per item,
// with tlast on the final byte, and returns one verdict item per buffer from
// the result register. Bytes are taken at one per cycle except in the stall below: each
// item passes an input register, updates the frame byte store (start byte,
// length, four control bytes, asdu header bytes, a byte counter saturating at
// 511) and, on the final byte, the checks run in one combinational pass into
// the result register. The only stall comes from the result side: a final
// byte waits in the input register while an earlier verdict is not yet taken,
// and the input register then fills. The verdict gives status, frame kind,
// sequence numbers, u function bits and the asdu header fields; header bytes
// outside the buffer read as zero, and on a short, bad start or overlong
// length verdict every field but status is zero. cause_bytes (index 0) and
// common_addr_bytes (index 1) pick one or two bytes (1 means one byte, any
// other value two) and both reset to 2; write them only while the block is
// idle. No clearing pass is needed after reset.
module iec104_apci_frame_checker_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // byte stream in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // data_byte
    input  logic                          s_tlast,   // last_byte
    // verdict stream out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, frame_kind, send_seq, recv_seq, u_function, asdu_type,
    // asdu_qualifier, cause, common_address, asdu_length, zero fill
    output logic [iafc_pkg::OutDataW-1:0] m_tdata,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [iafc_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [iafc_pkg::CfgW-1:0]     cfg_data
);
    import iafc_pkg::*;

    logic [CfgW-1:0] cause_bytes_reg;
    logic [CfgW-1:0] common_addr_bytes_reg;
    frame_t          frame_snap;
    logic            frame_done;
    logic            out_busy;
    result_t         result;
    result_t         result_reg;
    logic            m_valid_reg;

    // result register still holds an item that is not taken this cycle
    assign out_busy = m_valid_reg && !m_tready;

    iafc_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .out_busy   (out_busy),
        .frame_snap (frame_snap),
        .frame_done (frame_done)
    );

    iafc_verdict u_verdict (
        .frame_snap        (frame_snap),
        .cause_bytes       (cause_bytes_reg),
        .common_addr_bytes (common_addr_bytes_reg),
        .result            (result)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cause_bytes_reg       <= 2'd2;
            common_addr_bytes_reg <= 2'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAUSE_BYTES: cause_bytes_reg       <= cfg_data;
                CFG_ADDR_BYTES:  common_addr_bytes_reg <= cfg_data;
                default:         cause_bytes_reg       <= cause_bytes_reg;
            endcase
        end
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (frame_done)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OutDataW - ResultW){1'b0}}, result_reg};

endmodule
